// ----- src/bmdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmdq_pkg: shared types and constants for the battery mode dwell qualifier
// Beat payload structs, mode, class and recalibration codes, register map.
// ----------------------------------------------------------------------------
package bmdq_pkg;

  // Battery mode codes
  localparam logic [1:0] MODE_INIT        = 2'd0;
  localparam logic [1:0] MODE_WAIT        = 2'd1;
  localparam logic [1:0] MODE_CHARGING    = 2'd2;
  localparam logic [1:0] MODE_DISCHARGING = 2'd3;

  // Current class codes (also index of the class timer)
  localparam logic [1:0] CLS_REST      = 2'd0;
  localparam logic [1:0] CLS_CHARGE    = 2'd1;
  localparam logic [1:0] CLS_DISCHARGE = 2'd2;
  localparam int         NUM_CLS       = 3;

  // Recalibration source codes
  localparam logic [2:0] RECAL_NONE        = 3'd0;
  localparam logic [2:0] RECAL_HIGH_CELL   = 3'd1;
  localparam logic [2:0] RECAL_LOW_CELL    = 3'd2;
  localparam logic [2:0] RECAL_CHG_TABLE   = 3'd3;
  localparam logic [2:0] RECAL_DSG_TABLE   = 3'd4;
  localparam logic [2:0] RECAL_CUR_TABLE   = 3'd5;

  // Configuration port
  localparam int         CFG_ADDR_W = 8;
  localparam int         CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_REST_LIMIT   = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_DWELL = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REST_DWELL   = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPREAD_THR   = 8'd3;

  // Register reset values
  localparam logic [14:0] RST_REST_LIMIT   = 15'd1000;
  localparam logic [31:0] RST_ACTIVE_DWELL = 32'd10000;
  localparam logic [31:0] RST_REST_DWELL   = 32'd300000;
  localparam logic [15:0] RST_SPREAD_THR   = 16'd120;

  typedef struct packed {
    logic signed [15:0] pack_current;
    logic        [31:0] now_ticks;
    logic        [15:0] cell_spread_mv;
  } in_t;

  typedef struct packed {
    logic [1:0] battery_mode;
    logic [1:0] previous_mode;
    logic       mode_changed;
    logic [2:0] recal_source;
  } out_t;

  typedef struct packed {
    logic [14:0] rest_current_limit;
    logic [31:0] active_dwell_ticks;
    logic [31:0] rest_dwell_ticks;
    logic [15:0] spread_threshold_mv;
  } cfg_t;

endpackage

// ----- src/bmdq_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bmdq_cfg_regs: configuration register file
// Four writable registers; writes to unmapped indexes are dropped.
// ----------------------------------------------------------------------------
module bmdq_cfg_regs import bmdq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write beat
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_addr)
        REG_REST_LIMIT:   cfg_nxt.rest_current_limit  = cfg_data[14:0];
        REG_ACTIVE_DWELL: cfg_nxt.active_dwell_ticks  = cfg_data;
        REG_REST_DWELL:   cfg_nxt.rest_dwell_ticks    = cfg_data;
        REG_SPREAD_THR:   cfg_nxt.spread_threshold_mv = cfg_data[15:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest_current_limit  <= RST_REST_LIMIT;
      cfg_r.active_dwell_ticks  <= RST_ACTIVE_DWELL;
      cfg_r.rest_dwell_ticks    <= RST_REST_DWELL;
      cfg_r.spread_threshold_mv <= RST_SPREAD_THR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/bmdq_core.sv -----
// ----------------------------------------------------------------------------
// bmdq_core: classification, dwell timers and mode state
// Computes one result per sample and updates the mode state on each beat.
// ----------------------------------------------------------------------------
module bmdq_core import bmdq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t res
);

  logic [1:0]         mode_r, mode_nxt;
  logic [1:0]         prior_r, prior_nxt;
  logic [NUM_CLS-1:0] armed_r, armed_nxt;
  logic [31:0]        start_r [NUM_CLS];
  logic [31:0]        start_nxt [NUM_CLS];

  logic [1:0]  cls;
  logic [1:0]  target;
  logic [31:0] dwell;
  logic [31:0] sel_start;
  logic [31:0] elapsed;
  logic        changed;
  logic        spread_hi;
  logic [2:0]  recal;

  // Classify the current sample
  always_comb begin
    if (item.pack_current[15]) begin
      cls    = CLS_DISCHARGE;
      target = MODE_DISCHARGING;
      dwell  = cfg.active_dwell_ticks;
    end else if (item.pack_current[14:0] > cfg.rest_current_limit) begin
      cls    = CLS_CHARGE;
      target = MODE_CHARGING;
      dwell  = cfg.active_dwell_ticks;
    end else begin
      cls    = CLS_REST;
      target = MODE_WAIT;
      dwell  = cfg.rest_dwell_ticks;
    end
  end

  // Start time of the active class; elapsed wraps modulo 2^32
  always_comb begin
    unique case (cls)
      CLS_CHARGE:    sel_start = start_r[1];
      CLS_DISCHARGE: sel_start = start_r[2];
      default:       sel_start = start_r[0];
    endcase
  end

  assign elapsed = item.now_ticks - sel_start;

  // Timer and mode update
  always_comb begin
    mode_nxt  = mode_r;
    armed_nxt = armed_r;
    for (int k = 0; k < NUM_CLS; k++) begin
      start_nxt[k] = start_r[k];
    end
    if (mode_r == target) begin
      armed_nxt = '0;
    end else if (!armed_r[cls]) begin
      armed_nxt[cls] = 1'b1;
      for (int k = 0; k < NUM_CLS; k++) begin
        if (cls == k[1:0]) start_nxt[k] = item.now_ticks;
      end
    end else if (elapsed >= dwell) begin
      armed_nxt[cls] = 1'b0;
      mode_nxt       = target;
    end
    changed = (mode_nxt != mode_r);
    if (changed) armed_nxt = '0;
    prior_nxt = changed ? mode_r : prior_r;
  end

  // Recalibration source, only reported in wait mode
  assign spread_hi = (item.cell_spread_mv >= cfg.spread_threshold_mv);

  always_comb begin
    recal = RECAL_NONE;
    if (mode_nxt == MODE_WAIT) begin
      unique case (prior_nxt)
        MODE_CHARGING:    recal = spread_hi ? RECAL_HIGH_CELL : RECAL_CHG_TABLE;
        MODE_DISCHARGING: recal = spread_hi ? RECAL_LOW_CELL : RECAL_DSG_TABLE;
        MODE_INIT:        recal = spread_hi ? RECAL_NONE : RECAL_CUR_TABLE;
        default:          recal = RECAL_NONE;
      endcase
    end
  end

  assign res.battery_mode  = mode_nxt;
  assign res.previous_mode = prior_nxt;
  assign res.mode_changed  = changed;
  assign res.recal_source  = recal;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_INIT;
      prior_r <= MODE_INIT;
      armed_r <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      prior_r <= prior_nxt;
      armed_r <= armed_nxt;
    end
  end

  // Timer start stamps, qualified by the armed flags
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int k = 0; k < NUM_CLS; k++) begin
        start_r[k] <= start_nxt[k];
      end
    end
  end

  // The timer of the class that matches the current mode is never armed
  a_own_class_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !((mode_r == MODE_WAIT        && armed_r[0]) ||
      (mode_r == MODE_CHARGING    && armed_r[1]) ||
      (mode_r == MODE_DISCHARGING && armed_r[2])))
    else $error("timer armed for the class of the current mode");

  // A mode change leaves every timer disarmed
  a_change_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    fire && changed |=> armed_r == '0)
    else $error("timers still armed after mode change");

  // A change records the old mode as prior
  a_change_prior: assert property (@(posedge clk) disable iff (!rst_n)
    fire && changed |=> prior_r == $past(mode_r) && mode_r != prior_r)
    else $error("prior mode not updated on change");

  // Recal source is reported only in wait mode
  a_recal_wait: assert property (@(posedge clk) disable iff (!rst_n)
    recal != RECAL_NONE |-> mode_nxt == MODE_WAIT)
    else $error("recal source outside wait mode");

endmodule

// ----- src/battery_mode_dwell_qualifier.sv -----
// ----------------------------------------------------------------------------
// battery_mode_dwell_qualifier: battery mode tracking with dwell qualification
// Input register, single-pass classification and timer logic, result register.
// ----------------------------------------------------------------------------
// One current sample per cycle is accepted while the output is not stalled, and
// each yields exactly one result beat, through the input register and then the
// result register. The rate is set by the mode/timer update in the core: each
// sample reads the state the previous one left, so throughput is one beat per
// clock. The configuration port is always ready; write registers only while the
// block is idle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module battery_mode_dwell_qualifier import bmdq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  out_t res;

  logic s1_valid_r, s1_valid_nxt;
  in_t  s1_data_r;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  logic advance;
  logic fire;
  logic in_beat;

  assign cfg_ready = 1'b1;

  bmdq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline flow control
  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_beat  = in_valid && in_ready;

  assign s1_valid_nxt  = in_beat ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  bmdq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_beat) s1_data_r <= in_data;
    if (fire)    out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A held result beat is not overwritten while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("result beat lost under stall");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the battery mode dwell qualifier
// Drives current samples through the valid/ready input channel and checks each
// result beat against an in-bench model of the mode and dwell-timer logic.
// Covers directed mode walks, register extremes and random class runs.
// ----------------------------------------------------------------------------
module tb_top;
  import bmdq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 24;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] idx;
    logic [CFG_DATA_W-1:0] val;
  } reg_write_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  in_t        pending_samples[$];
  reg_write_t pending_writes[$];
  out_t       expected_reports[$];

  // Register copies and qualifier state
  logic [14:0] rest_limit_r;
  logic [31:0] active_dwell_r;
  logic [31:0] rest_dwell_r;
  logic [15:0] spread_thr_r;
  logic [1:0]  mode_r;
  logic [1:0]  prior_r;
  logic [31:0] class_t0[NUM_CLS];
  logic        class_armed[NUM_CLS];

  int   errs   = 0;
  int   cycles = 0;
  logic calm   = 1'b0;
  out_t want;

  battery_mode_dwell_qualifier DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Qualifier model
  // ---------------------------------------------------------------------------
  function automatic void disarm_timers();
    for (int k = 0; k < NUM_CLS; k++) begin
      class_armed[k] = 1'b0;
      class_t0[k]    = '0;
    end
  endfunction

  function automatic void apply_reg_write(reg_write_t w);
    case (w.idx)
      REG_REST_LIMIT:   rest_limit_r   = w.val[14:0];
      REG_ACTIVE_DWELL: active_dwell_r = w.val;
      REG_REST_DWELL:   rest_dwell_r   = w.val;
      REG_SPREAD_THR:   spread_thr_r   = w.val[15:0];
      default: ; // unmapped index, no effect
    endcase
  endfunction

  // Update mode state for one sample and return the report it produces
  function automatic out_t next_mode_report(in_t s);
    int          cur;
    logic [1:0]  cls;
    logic [1:0]  target;
    logic [1:0]  nxt;
    logic [31:0] dwell;
    logic [31:0] elapsed;
    out_t        r;
    cur = $signed(s.pack_current);
    if (cur < 0) begin
      cls = CLS_DISCHARGE; target = MODE_DISCHARGING; dwell = active_dwell_r;
    end else if (cur > int'(rest_limit_r)) begin
      cls = CLS_CHARGE; target = MODE_CHARGING; dwell = active_dwell_r;
    end else begin
      cls = CLS_REST; target = MODE_WAIT; dwell = rest_dwell_r;
    end
    nxt = mode_r;
    elapsed = s.now_ticks - class_t0[cls];
    if (mode_r == target) begin
      disarm_timers();
    end else if (!class_armed[cls]) begin
      class_armed[cls] = 1'b1;
      class_t0[cls]    = s.now_ticks;
    end else if (elapsed >= dwell) begin
      class_armed[cls] = 1'b0;
      class_t0[cls]    = '0;
      nxt = target;
    end
    r.mode_changed = 1'b0;
    if (nxt != mode_r) begin
      disarm_timers();
      prior_r = mode_r;
      mode_r  = nxt;
      r.mode_changed = 1'b1;
    end
    // recalibration source only reported while waiting
    r.recal_source = RECAL_NONE;
    if (mode_r == MODE_WAIT) begin
      if (s.cell_spread_mv >= spread_thr_r) begin
        if (prior_r == MODE_CHARGING) r.recal_source = RECAL_HIGH_CELL;
        else if (prior_r == MODE_DISCHARGING) r.recal_source = RECAL_LOW_CELL;
      end else begin
        case (prior_r)
          MODE_CHARGING:    r.recal_source = RECAL_CHG_TABLE;
          MODE_DISCHARGING: r.recal_source = RECAL_DSG_TABLE;
          MODE_INIT:        r.recal_source = RECAL_CUR_TABLE;
          default:          r.recal_source = RECAL_NONE;
        endcase
      end
    end
    r.battery_mode  = mode_r;
    r.previous_mode = prior_r;
    return r;
  endfunction

  function automatic logic idle_roll();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: predicts on each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_reports.push_back(next_mode_report(in_data));
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && !idle_roll()) begin
          in_valid <= 1'b1;
          in_data  <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_reg_write('{idx: cfg_addr, val: cfg_data});
      if (!cfg_valid || cfg_ready) begin
        if (pending_writes.size() != 0 && !idle_roll()) begin
          cfg_valid <= 1'b1;
          {cfg_addr, cfg_data} <= pending_writes.pop_front();
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  task automatic check_field(string fname, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      errs++;
      $display("%0t: %s expected %0d got %0d", $time, fname, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          errs++;
          $display("%0t: no result expected, got %p", $time, out_data);
        end else begin
          want = expected_reports.pop_front();
          check_field("battery_mode",  want.battery_mode,  out_data.battery_mode);
          check_field("previous_mode", want.previous_mode, out_data.previous_mode);
          check_field("mode_changed",  want.mode_changed,  out_data.mode_changed);
          check_field("recal_source",  want.recal_source,  out_data.recal_source);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("battery_mode_dwell_qualifier: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_sample(int cur, logic [31:0] now, int spr);
    in_t s;
    s.pack_current   = cur[15:0];
    s.now_ticks      = now;
    s.cell_spread_mv = spr[15:0];
    pending_samples.push_back(s);
  endtask

  task automatic set_regs(logic [31:0] lim, logic [31:0] act, logic [31:0] rst_d,
                          logic [31:0] thr);
    pending_writes.push_back('{idx: REG_REST_LIMIT,   val: lim});
    pending_writes.push_back('{idx: REG_ACTIVE_DWELL, val: act});
    pending_writes.push_back('{idx: REG_REST_DWELL,   val: rst_d});
    pending_writes.push_back('{idx: REG_SPREAD_THR,   val: thr});
    while (pending_writes.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
  endtask

  // Runs of same-class samples with advancing timestamps, plus raw noise
  task automatic add_runs(int count, int step_max, int noise_pct);
    logic [31:0] t;
    int          left;
    int          run;
    int          cls;
    int          cur;
    int          spr;
    int          k;
    in_t         s;
    t = $urandom();
    if ($urandom_range(3) == 0) t = 32'hFFFF_FFFF - $urandom_range(3000);
    left = count;
    while (left > 0) begin
      cls = $urandom_range(2);
      run = $urandom_range(30, 1);
      for (k = 0; k < run && left > 0; k++) begin
        t += $urandom_range(step_max);
        if ($urandom_range(99) < noise_pct) begin
          s.pack_current   = 16'($urandom());
          s.now_ticks      = $urandom();
          s.cell_spread_mv = 16'($urandom());
          pending_samples.push_back(s);
        end else begin
          if (cls == 2) cur = -int'($urandom_range(32768, 1));
          else if (cls == 1 && rest_limit_r != 15'h7FFF)
            cur = $urandom_range(32767, int'(rest_limit_r) + 1);
          else cur = $urandom_range(int'(rest_limit_r), 0);
          if ($urandom_range(1) == 0) begin
            spr = int'(spread_thr_r) + int'($urandom_range(4)) - 2;
            if (spr < 0) spr = 0;
            if (spr > 65535) spr = 65535;
          end else begin
            spr = $urandom_range(65535);
          end
          add_sample(cur, t, spr);
        end
        left--;
      end
    end
  endtask

  initial begin
    rest_limit_r   = RST_REST_LIMIT;
    active_dwell_r = RST_ACTIVE_DWELL;
    rest_dwell_r   = RST_REST_DWELL;
    spread_thr_r   = RST_SPREAD_THR;
    mode_r         = MODE_INIT;
    prior_r        = MODE_INIT;
    disarm_timers();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk through every mode with reset register values
    add_sample(0,      0,      0);       // arm rest
    add_sample(1000,   299999, 65535);   // one tick short of rest dwell
    add_sample(500,    300000, 119);     // enter wait from init, below threshold
    add_sample(1000,   300001, 120);     // spread at threshold, prior init
    add_sample(1001,   300002, 0);       // arm charge
    add_sample(0,      300003, 0);       // class matches mode, timers cleared
    add_sample(32767,  310002, 0);       // charge re-armed, not switched
    add_sample(32767,  320001, 0);
    add_sample(1001,   320002, 65535);   // charging
    add_sample(-1,     320003, 0);
    add_sample(-32768, 330003, 0);       // discharging
    add_sample(0,      330004, 0);
    add_sample(1000,   630004, 0);       // wait after discharge, discharge table
    add_sample(5,      630005, 200);     // lowest cell
    add_sample(2000,   630006, 10);
    add_sample(2000,   640006, 10);      // charging from wait
    add_sample(0,      640007, 10);
    add_sample(0,      940007, 10);      // wait after charge, charge table
    add_sample(0,      940008, 120);     // highest cell
    add_sample(-5,     32'hFFFF_F000, 0);
    add_sample(-5,     32'h0000_1710, 0); // elapsed across timestamp wrap
    add_sample(-5,     0, 0);
    drain();

    // Zero dwell and zero limit and threshold
    set_regs(0, 0, 0, 0);
    add_runs(40, 3, 10);
    drain();

    // Maximum registers, plus writes to unmapped indexes
    pending_writes.push_back('{idx: 8'd4,   val: $urandom()});
    pending_writes.push_back('{idx: 8'd255, val: $urandom()});
    set_regs(32'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF);
    add_runs(40, 1000, 50);
    drain();

    // Random register settings with random class runs
    for (int ph = 0; ph < 8; ph++) begin
      set_regs(($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(2000),
               $urandom_range(60), $urandom_range(200), $urandom_range(300));
      calm = (ph == 2);
      add_runs(180, 20, 10);
      drain();
    end
    calm = 1'b0;

    repeat (10) @(negedge clk);
    if (errs == 0) begin
      $display("battery_mode_dwell_qualifier: match");
    end else begin
      $display("battery_mode_dwell_qualifier: mismatch");
    end
    $finish;
  end

endmodule
